@@ hdl/fslc_pkg.sv @@
// ----------------------------------------------------------------------------
// Floppy switch-latch controller package
// Codes, latch positions and reset values shared by the controller.
// ----------------------------------------------------------------------------
package fslc_pkg;

    // Default width of the motor-off countdown.
    localparam int DELAY_WIDTH_DEFAULT = 24;

    // Width of the motor-off delay register on the configuration port.
    localparam int CFG_TICKS_WIDTH = 24;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int APB_ADDR_WIDTH  = 3;

    // Register index decoded from the word address.
    localparam logic REG_DELAY_TICKS = 1'b0;

    // Item kinds.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Positions of the eight soft-switch latches.
    localparam int LT_PH1   = 1;
    localparam int LT_PH3   = 3;
    localparam int LT_MOTOR = 4;
    localparam int LT_DRIVE = 5;
    localparam int LT_Q6    = 6;
    localparam int LT_Q7    = 7;

    // Mode register bit that turns the motor off without the delay.
    localparam int MODE_IMMEDIATE_OFF = 2;

    // Soft-switch offsets with side effects on the drive enable.
    localparam logic [3:0] OFF_MOTOR_OFF     = 4'h8;
    localparam logic [3:0] OFF_MOTOR_ON      = 4'h9;
    localparam logic [3:0] OFF_SELECT_FIRST  = 4'hA;
    localparam logic [3:0] OFF_SELECT_SECOND = 4'hB;

    // Q7/Q6 read register selection, Q7 in the upper bit.
    localparam logic [1:0] QSEL_DATA      = 2'b00;
    localparam logic [1:0] QSEL_STATUS    = 2'b01;
    localparam logic [1:0] QSEL_HANDSHAKE = 2'b10;
    localparam logic [1:0] QSEL_WRITE     = 2'b11;

    // Drive enable codes.
    localparam logic [1:0] ENABLE_NONE   = 2'd0;
    localparam logic [1:0] ENABLE_FIRST  = 2'd1;
    localparam logic [1:0] ENABLE_SECOND = 2'd2;

    // Handshake register values and the last step of its five-read cycle.
    localparam logic [7:0] HS_BYTE_BUSY = 8'hC0;
    localparam logic [7:0] HS_BYTE_IDLE = 8'h80;
    localparam logic [2:0] HS_LAST_STEP = 3'd4;

    // Reset values.
    localparam logic [4:0]                 MODE_RESET        = 5'h1F;
    localparam logic [CFG_TICKS_WIDTH-1:0] DELAY_TICKS_RESET = 24'd1000;

endpackage

@@ hdl/floppy_switch_latch_controller.sv @@
// ----------------------------------------------------------------------------
// Floppy switch-latch controller
// Sixteen soft-switch addresses driving eight latches, a mode register,
// a read handshake pattern and a motor-off countdown for two drives.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    func, offset, wdata, drive_sense,
//                                          drive_byte
//  m_        out        m_valid/m_ready    read_byte, phase_out, enable_out,
//                                          drive_read_taken, write_strobe,
//                                          write_byte
//  APB       in/out     psel/penable       motor_off_delay_ticks at 0x0
//
//  Each transaction is captured in an input register; when it advances,
//  the controller state and the result register are updated together.
//  Throughput is one transaction per clock while the result is not stalled
//  by m_ready.
//  Reset (aresetn low, synchronous) clears the latches, the handshake step,
//  the enable and the countdown, and loads the mode and delay registers.
//  A stalled result holds in the output register while the input register
//  can still take one more transaction.
//
module floppy_switch_latch_controller #(
    parameter int DELAY_WIDTH = fslc_pkg::DELAY_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [3:0]                          s_offset,
    input  logic [7:0]                          s_wdata,
    input  logic                                s_drive_sense,
    input  logic [7:0]                          s_drive_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_read_byte,
    output logic [3:0]                          m_phase_out,
    output logic [1:0]                          m_enable_out,
    output logic                                m_drive_read_taken,
    output logic                                m_write_strobe,
    output logic [7:0]                          m_write_byte,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fslc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [fslc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [fslc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import fslc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register. Word addressing: bit 2 of paddr picks the
    // register, and only index zero exists.
    // ------------------------------------------------------------------
    logic [CFG_TICKS_WIDTH-1:0] delay_ticks_reg;
    logic                       cfg_write;
    logic                       cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_TICKS_RESET;
        end else if (cfg_write && (cfg_index == REG_DELAY_TICKS)) begin
            delay_ticks_reg <= pwdata[CFG_TICKS_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_index == REG_DELAY_TICKS) begin
            prdata[CFG_TICKS_WIDTH-1:0] = delay_ticks_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register. It is free again whenever its transaction moves on
    // into the result register, so the input side keeps flowing while a
    // result waits on m_ready.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [3:0] in_offset_reg;
    logic [7:0] in_wdata_reg;
    logic       in_sense_reg;
    logic [7:0] in_dbyte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg   <= s_func;
            in_offset_reg <= s_offset;
            in_wdata_reg  <= s_wdata;
            in_sense_reg  <= s_drive_sense;
            in_dbyte_reg  <= s_drive_byte;
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    logic [7:0]             latches_reg,   latches_next;
    logic [4:0]             mode_reg,      mode_next;
    logic [2:0]             hs_step_reg,   hs_step_next;
    logic [1:0]             enable_reg,    enable_next;
    logic                   running_reg,   running_next;
    logic [DELAY_WIDTH-1:0] delay_left_reg, delay_left_next;

    // The delay register is zero-extended or cut to the countdown width,
    // and a zero setting counts as one tick.
    logic [31:0]            ticks_wide;
    logic [DELAY_WIDTH-1:0] ticks_raw;
    logic [DELAY_WIDTH-1:0] ticks_load;
    logic [DELAY_WIDTH-1:0] delay_left_dec;

    assign ticks_wide     = {{(32 - CFG_TICKS_WIDTH){1'b0}}, delay_ticks_reg};
    assign ticks_raw      = ticks_wide[DELAY_WIDTH-1:0];
    assign ticks_load     = (ticks_raw == '0) ? DELAY_WIDTH'(1) : ticks_raw;
    assign delay_left_dec = delay_left_reg - DELAY_WIDTH'(1);

    logic [7:0] rbyte;
    logic       taken;
    logic       strobe;
    logic [7:0] wbyte;
    logic [1:0] qsel;

    assign qsel = {latches_next[LT_Q7], latches_next[LT_Q6]};

    always_comb begin
        latches_next    = latches_reg;
        mode_next       = mode_reg;
        hs_step_next    = hs_step_reg;
        enable_next     = enable_reg;
        running_next    = running_reg;
        delay_left_next = delay_left_reg;
        rbyte           = '0;
        taken           = 1'b0;
        strobe          = 1'b0;
        wbyte           = '0;

        unique case (in_func_reg) inside
            FUNC_READ, FUNC_WRITE: begin
                // Every bus access sets or clears one latch first.
                latches_next[in_offset_reg[3:1]] = in_offset_reg[0];

                unique case (in_offset_reg)
                    OFF_MOTOR_OFF: begin
                        if (mode_reg[MODE_IMMEDIATE_OFF]) begin
                            latches_next[LT_MOTOR] = 1'b0;
                            enable_next            = ENABLE_NONE;
                        end else if (!running_reg) begin
                            // A pending countdown keeps its earlier expiry.
                            delay_left_next = ticks_load;
                            running_next    = 1'b1;
                        end
                    end
                    OFF_MOTOR_ON: begin
                        latches_next[LT_MOTOR] = 1'b1;
                        enable_next = latches_next[LT_DRIVE] ? ENABLE_SECOND : ENABLE_FIRST;
                    end
                    OFF_SELECT_FIRST: begin
                        if (latches_next[LT_MOTOR]) begin
                            enable_next = ENABLE_FIRST;
                        end
                    end
                    OFF_SELECT_SECOND: begin
                        if (latches_next[LT_MOTOR]) begin
                            enable_next = ENABLE_SECOND;
                        end
                    end
                    default: begin
                    end
                endcase

                if (in_func_reg == FUNC_READ) begin
                    if (!in_offset_reg[0]) begin
                        case (qsel)
                            QSEL_DATA: begin
                                rbyte = in_dbyte_reg;
                                taken = 1'b1;
                            end
                            QSEL_STATUS: begin
                                rbyte = {in_sense_reg, 1'b0, latches_next[LT_MOTOR], mode_reg};
                            end
                            QSEL_HANDSHAKE: begin
                                if (latches_next[LT_PH1] && latches_next[LT_PH3]) begin
                                    if (hs_step_reg >= HS_LAST_STEP) begin
                                        hs_step_next = '0;
                                        rbyte        = HS_BYTE_IDLE;
                                    end else begin
                                        hs_step_next = hs_step_reg + 3'd1;
                                        rbyte        = HS_BYTE_BUSY;
                                    end
                                end else begin
                                    rbyte = HS_BYTE_IDLE;
                                end
                            end
                            default: begin
                                rbyte = '0;
                            end
                        endcase
                    end
                end else if (in_offset_reg[0] && (qsel == QSEL_WRITE)) begin
                    if (!latches_next[LT_MOTOR]) begin
                        mode_next = in_wdata_reg[4:0];
                    end else begin
                        strobe = 1'b1;
                        wbyte  = in_wdata_reg;
                    end
                end
            end
            FUNC_TICK: begin
                if (running_reg) begin
                    delay_left_next = delay_left_dec;
                    if (delay_left_dec == '0) begin
                        // Expiry turns the motor off even if it was turned
                        // on again while the countdown ran.
                        running_next           = 1'b0;
                        latches_next[LT_MOTOR] = 1'b0;
                        enable_next            = ENABLE_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latches_reg    <= '0;
            mode_reg       <= MODE_RESET;
            hs_step_reg    <= '0;
            enable_reg     <= ENABLE_NONE;
            running_reg    <= 1'b0;
            delay_left_reg <= '0;
        end else if (advance) begin
            latches_reg    <= latches_next;
            mode_reg       <= mode_next;
            hs_step_reg    <= hs_step_next;
            enable_reg     <= enable_next;
            running_reg    <= running_next;
            delay_left_reg <= delay_left_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [7:0] rbyte_reg;
    logic [3:0] phase_reg;
    logic [1:0] enable_out_reg;
    logic       taken_reg;
    logic       strobe_reg;
    logic [7:0] wbyte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rbyte_reg      <= rbyte;
            phase_reg      <= latches_next[3:0];
            enable_out_reg <= enable_next;
            taken_reg      <= taken;
            strobe_reg     <= strobe;
            wbyte_reg      <= wbyte;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_read_byte        = rbyte_reg;
    assign m_phase_out        = phase_reg;
    assign m_enable_out       = enable_out_reg;
    assign m_drive_read_taken = taken_reg;
    assign m_write_strobe     = strobe_reg;
    assign m_write_byte       = wbyte_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A running countdown never sits at zero ticks left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (delay_left_reg != '0))
        else $error("countdown running with zero ticks left");

    // The handshake step stays within its five-read cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hs_step_reg <= HS_LAST_STEP)
        else $error("handshake step out of range");

    // A transaction waiting behind a stalled result is kept, not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("queued transaction lost during output stall");

    // A drive write never carries a read value at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_strobe) |-> (m_read_byte == '0 && !m_drive_read_taken))
        else $error("write strobe together with read data");

    // The drive enable only ever names one of the two drives or none.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (enable_reg == ENABLE_NONE) || (enable_reg == ENABLE_FIRST)
            || (enable_reg == ENABLE_SECOND))
        else $error("invalid drive enable");

endmodule
